@@ rtl/fed_pkg.sv @@
package fed_pkg;

   localparam int SAMPLE_BITS  = 24;
   localparam int DEPTH_BITS   = 16;
   localparam int CHANNELS     = 2;
   localparam int CH_BITS      = 1;
   localparam int RING_WORDS   = CHANNELS << DEPTH_BITS;
   localparam int GAIN_BITS    = 16;
   localparam int Q_BITS       = GAIN_BITS + 1;
   localparam int Q_FRAC       = 15;
   localparam int PROD_BITS    = SAMPLE_BITS + Q_BITS + 1;
   localparam int SUM_BITS     = SAMPLE_BITS + 2;
   localparam int CSR_BITS     = 2;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_BITS   = 2;

   localparam logic [Q_BITS-1:0] UNITY = Q_BITS'(32768);

   typedef enum logic [CSR_BITS-1:0] {
      CSR_DELAY    = 2'd0,
      CSR_FEEDBACK = 2'd1,
      CSR_WET_MIX  = 2'd2
   } csr_index_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   // one queued item, classified by the front end
   typedef struct packed {
      logic                  chan;
      logic [CH_BITS-1:0]    ring;
      logic [DEPTH_BITS-1:0] waddr;
      logic [DEPTH_BITS-1:0] raddr;
      logic                  rvalid;
      sample_type            dry;
   } item_type;

   localparam logic signed [SUM_BITS-1:0] SAT_HI =
      {{(SUM_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SAT_LO =
      {{(SUM_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

   function automatic logic [Q_BITS-1:0] clamp_gain(input logic [GAIN_BITS-1:0] g);
      logic [Q_BITS-1:0] gw;
      gw = {1'b0, g};
      return (gw > UNITY) ? UNITY : gw;
   endfunction

   function automatic sample_type sat_sample(input logic signed [SUM_BITS-1:0] v);
      sample_type r;
      if (v > SAT_HI) begin
         r = sample_type'(SAT_HI[SAMPLE_BITS-1:0]);
      end else if (v < SAT_LO) begin
         r = sample_type'(SAT_LO[SAMPLE_BITS-1:0]);
      end else begin
         r = sample_type'(v[SAMPLE_BITS-1:0]);
      end
      return r;
   endfunction

endpackage

@@ rtl/fed_front.sv @@
module fed_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_chan,
   input  fed_pkg::sample_type             req_sample_in,
   input  logic [fed_pkg::DEPTH_BITS-1:0]  delay,
   input  logic                            q_full,
   output logic                            q_push,
   output fed_pkg::item_type               q_item
);

   logic [fed_pkg::DEPTH_BITS-1:0] wptr_ff [fed_pkg::CHANNELS];
   logic [fed_pkg::DEPTH_BITS-1:0] wptr_in [fed_pkg::CHANNELS];
   logic [fed_pkg::CHANNELS-1:0]   wrap_ff;
   logic [fed_pkg::CHANNELS-1:0]   wrap_in;
   logic [fed_pkg::CH_BITS-1:0]    ring;
   logic [fed_pkg::DEPTH_BITS-1:0] w;
   logic [fed_pkg::DEPTH_BITS-1:0] rd;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;
   assign ring      = fed_pkg::CH_BITS'(req_chan);
   assign w         = wptr_ff[ring];
   assign rd        = w - delay;

   // entry rd holds a written value once the ring has wrapped or rd lies behind w
   always_comb begin
      q_item.chan   = req_chan;
      q_item.ring   = ring;
      q_item.waddr  = w;
      q_item.raddr  = rd;
      q_item.rvalid = wrap_ff[ring] || (rd < w);
      q_item.dry    = req_sample_in;
   end

   always_comb begin
      wptr_in = wptr_ff;
      wrap_in = wrap_ff;
      if (q_push) begin
         wptr_in[ring] = w + 1'b1;
         if (w == {fed_pkg::DEPTH_BITS{1'b1}}) begin
            wrap_in[ring] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fed_pkg::CHANNELS; i++) begin
            wptr_ff[i] <= '0;
         end
         wrap_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         wrap_ff <= wrap_in;
      end
   end

endmodule

@@ rtl/fed_queue.sv @@
module fed_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fed_pkg::item_type push_item,
   input  logic              pop,
   output fed_pkg::item_type head,
   output logic              empty,
   output logic              full
);

   fed_pkg::item_type              slot_ff [fed_pkg::QUEUE_DEPTH];
   fed_pkg::item_type              slot_in [fed_pkg::QUEUE_DEPTH];
   logic [fed_pkg::QUEUE_BITS-1:0] rd_ptr_ff;
   logic [fed_pkg::QUEUE_BITS-1:0] rd_ptr_in;
   logic [fed_pkg::QUEUE_BITS-1:0] wr_ptr_ff;
   logic [fed_pkg::QUEUE_BITS-1:0] wr_ptr_in;
   logic [fed_pkg::QUEUE_BITS:0]   count_ff;
   logic [fed_pkg::QUEUE_BITS:0]   count_in;
   logic                           do_push;
   logic                           do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (fed_pkg::QUEUE_BITS+1)'(fed_pkg::QUEUE_DEPTH));
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      slot_in   = slot_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         slot_in[wr_ptr_ff] = push_item;
         wr_ptr_in          = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/fed_back.sv @@
module fed_back (
   input  logic                           clock,
   input  logic                           reset,
   input  fed_pkg::item_type              head,
   input  logic                           head_valid,
   output logic                           pop,
   input  logic [fed_pkg::GAIN_BITS-1:0]  feedback_gain,
   input  logic [fed_pkg::GAIN_BITS-1:0]  wet_mix,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_chan_out,
   output fed_pkg::sample_type            rsp_sample_out
);

   localparam int ADDR_BITS = fed_pkg::CH_BITS + fed_pkg::DEPTH_BITS;
   localparam int HI        = fed_pkg::Q_FRAC + fed_pkg::SAMPLE_BITS;

   fed_pkg::sample_type ring_mem [fed_pkg::RING_WORDS];

   // execute stage
   logic                        e_valid_ff, e_valid_in;
   fed_pkg::item_type           e_item_ff, e_item_in;
   fed_pkg::sample_type         rdata_ff;
   // last write, for read-after-write forwarding
   logic                        fwd_valid_ff, fwd_valid_in;
   logic [ADDR_BITS-1:0]        fwd_addr_ff, fwd_addr_in;
   fed_pkg::sample_type         fwd_data_ff, fwd_data_in;
   // mix stage
   logic                        m_valid_ff, m_valid_in;
   logic                        m_chan_ff, m_chan_in;
   logic signed [fed_pkg::PROD_BITS-1:0] m_dry_ff, m_dry_in;
   logic signed [fed_pkg::PROD_BITS-1:0] m_wet_ff, m_wet_in;
   // output register
   logic                        o_valid_ff, o_valid_in;
   logic                        o_chan_ff, o_chan_in;
   fed_pkg::sample_type         o_sample_ff, o_sample_in;

   logic                        o_ready, m_ready, e_ready;
   logic                        e_fire, m_fire;
   logic [ADDR_BITS-1:0]        raddr, e_raddr, e_waddr;
   logic [fed_pkg::Q_BITS-1:0]  fb_q, mix_q, dry_q;
   logic signed [fed_pkg::Q_BITS:0] fb_s, mix_s, dry_s;
   fed_pkg::sample_type         delayed;
   logic signed [fed_pkg::PROD_BITS-1:0] fb_prod;
   logic signed [fed_pkg::SUM_BITS-1:0]  wr_sum, y_sum;
   fed_pkg::sample_type         wr;

   assign o_ready = !o_valid_ff || rsp_ready;
   assign m_ready = !m_valid_ff || o_ready;
   assign e_ready = !e_valid_ff || m_ready;
   assign pop     = head_valid && e_ready;
   assign e_fire  = e_valid_ff && m_ready;
   assign m_fire  = m_valid_ff && o_ready;

   assign raddr   = {head.ring, head.raddr};
   assign e_raddr = {e_item_ff.ring, e_item_ff.raddr};
   assign e_waddr = {e_item_ff.ring, e_item_ff.waddr};

   assign fb_q  = fed_pkg::clamp_gain(feedback_gain);
   assign mix_q = fed_pkg::clamp_gain(wet_mix);
   assign dry_q = fed_pkg::UNITY - mix_q;
   assign fb_s  = {1'b0, fb_q};
   assign mix_s = {1'b0, mix_q};
   assign dry_s = {1'b0, dry_q};

   always_comb begin
      if (!e_item_ff.rvalid) begin
         delayed = '0;
      end else if (fwd_valid_ff && (fwd_addr_ff == e_raddr)) begin
         delayed = fwd_data_ff;
      end else begin
         delayed = rdata_ff;
      end
   end

   assign fb_prod = delayed * fb_s;
   assign wr_sum  = fed_pkg::SUM_BITS'(e_item_ff.dry)
                  + fed_pkg::SUM_BITS'($signed(fb_prod[HI:fed_pkg::Q_FRAC]));
   assign wr      = fed_pkg::sat_sample(wr_sum);

   assign y_sum   = fed_pkg::SUM_BITS'($signed(m_dry_ff[HI:fed_pkg::Q_FRAC]))
                  + fed_pkg::SUM_BITS'($signed(m_wet_ff[HI:fed_pkg::Q_FRAC]));

   always_comb begin
      e_valid_in   = e_valid_ff;
      e_item_in    = e_item_ff;
      fwd_valid_in = fwd_valid_ff;
      fwd_addr_in  = fwd_addr_ff;
      fwd_data_in  = fwd_data_ff;
      m_valid_in   = m_valid_ff;
      m_chan_in    = m_chan_ff;
      m_dry_in     = m_dry_ff;
      m_wet_in     = m_wet_ff;
      o_valid_in   = o_valid_ff;
      o_chan_in    = o_chan_ff;
      o_sample_in  = o_sample_ff;

      if (e_ready) begin
         e_valid_in = pop;
         if (pop) begin
            e_item_in = head;
         end
      end
      if (e_fire) begin
         fwd_valid_in = 1'b1;
         fwd_addr_in  = e_waddr;
         fwd_data_in  = wr;
      end
      if (m_ready) begin
         m_valid_in = e_valid_ff;
         if (e_valid_ff) begin
            m_chan_in = e_item_ff.chan;
            m_dry_in  = e_item_ff.dry * dry_s;
            m_wet_in  = delayed * mix_s;
         end
      end
      if (o_ready) begin
         o_valid_in = m_valid_ff;
         if (m_valid_ff) begin
            o_chan_in   = m_chan_ff;
            o_sample_in = fed_pkg::sat_sample(y_sum);
         end
      end
   end

   // ring memory: one registered read on pop, one write as an item leaves execute
   always_ff @(posedge clock) begin
      if (pop) begin
         rdata_ff <= ring_mem[raddr];
      end
      if (e_fire) begin
         ring_mem[e_waddr] <= wr;
      end
   end

   always_ff @(posedge clock) begin
      e_item_ff   <= e_item_in;
      fwd_addr_ff <= fwd_addr_in;
      fwd_data_ff <= fwd_data_in;
      m_chan_ff   <= m_chan_in;
      m_dry_ff    <= m_dry_in;
      m_wet_ff    <= m_wet_in;
      o_chan_ff   <= o_chan_in;
      o_sample_ff <= o_sample_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
         m_valid_ff   <= 1'b0;
         o_valid_ff   <= 1'b0;
      end else begin
         e_valid_ff   <= e_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         m_valid_ff   <= m_valid_in;
         o_valid_ff   <= o_valid_in;
      end
   end

   assign rsp_valid      = o_valid_ff;
   assign rsp_chan_out   = o_chan_ff;
   assign rsp_sample_out = o_sample_ff;

endmodule

@@ rtl/feedback_echo_delay.sv @@
// An accepted item passes the queue, execute, mix and output registers in turn.
// Throughput: one item per cycle, stalls aside; the ring memory takes one read
// and one write per cycle; the last write is forwarded to a read of its entry.
// Reset: control, write pointers and valid flags clear at once; ring entries not
// yet written since reset read as zero through per-channel fill tracking.
module feedback_echo_delay (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_chan,
   input  logic signed [23:0]             req_sample_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_chan_out,
   output logic signed [23:0]             rsp_sample_out,
   input  logic                           csr_we,
   input  logic [fed_pkg::CSR_BITS-1:0]   csr_index,
   input  logic [fed_pkg::GAIN_BITS-1:0]  csr_wdata
);

   logic [fed_pkg::DEPTH_BITS-1:0] delay_ff, delay_in;
   logic [fed_pkg::GAIN_BITS-1:0]  feedback_ff, feedback_in;
   logic [fed_pkg::GAIN_BITS-1:0]  wet_mix_ff, wet_mix_in;

   logic              q_push, q_pop, q_empty, q_full;
   fed_pkg::item_type q_item, q_head;

   always_comb begin
      delay_in    = delay_ff;
      feedback_in = feedback_ff;
      wet_mix_in  = wet_mix_ff;
      if (csr_we) begin
         case (csr_index)
            fed_pkg::CSR_DELAY:    delay_in    = fed_pkg::DEPTH_BITS'(csr_wdata);
            fed_pkg::CSR_FEEDBACK: feedback_in = csr_wdata;
            fed_pkg::CSR_WET_MIX:  wet_mix_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff    <= '0;
         feedback_ff <= '0;
         wet_mix_ff  <= '0;
      end else begin
         delay_ff    <= delay_in;
         feedback_ff <= feedback_in;
         wet_mix_ff  <= wet_mix_in;
      end
   end

   fed_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_chan      (req_chan),
      .req_sample_in (req_sample_in),
      .delay         (delay_ff),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_item        (q_item)
   );

   fed_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   fed_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (q_head),
      .head_valid     (!q_empty),
      .pop            (q_pop),
      .feedback_gain  (feedback_ff),
      .wet_mix        (wet_mix_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_chan_out   (rsp_chan_out),
      .rsp_sample_out (rsp_sample_out)
   );

`ifndef NO_ASSERTIONS
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !q_empty)
      else $error("accepted item did not reach the queue");

   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty))
      else $error("queue both full and empty");

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty queue");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule

@@ verif/echo_checker.sv @@
module echo_checker
   import fed_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_chan,
   input  sample_type            req_sample_in,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_chan_out,
   input  sample_type            rsp_sample_out,
   input  logic                  csr_we,
   input  logic [CSR_BITS-1:0]   csr_index,
   input  logic [GAIN_BITS-1:0]  csr_wdata,
   output int                    fail_count,
   output int                    echo_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint Q15_ONE = 32768;
   localparam longint SAT_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
   localparam longint SAT_MIN = -SAT_MAX - 1;

   typedef struct packed {
      logic       chan;
      sample_type sample;
   } echo_out_t;

   sample_type            echo_ring [CHANNELS][1 << DEPTH_BITS];
   logic [DEPTH_BITS-1:0] write_ptr [CHANNELS];
   logic [GAIN_BITS-1:0]  delay_reg;
   logic [GAIN_BITS-1:0]  feedback_reg;
   logic [GAIN_BITS-1:0]  wet_reg;
   echo_out_t             echo_due [$];
   int                    errors = 0;

   function automatic longint clip_sample(input longint v);
      return (v > SAT_MAX) ? SAT_MAX : ((v < SAT_MIN) ? SAT_MIN : v);
   endfunction

   function automatic longint to_q15(input logic [GAIN_BITS-1:0] g);
      return (g > Q15_ONE) ? Q15_ONE : longint'(g);
   endfunction

   // read the delayed tap, write back with feedback, mix dry and wet
   task automatic predict_echo(input logic ch, input sample_type dry_in);
      longint                dry;
      longint                delayed;
      longint                fb;
      longint                mix;
      longint                fed_back;
      longint                mixed;
      logic [DEPTH_BITS-1:0] rd;
      echo_out_t             want;
      dry      = dry_in;
      rd       = write_ptr[ch] - delay_reg;
      delayed  = echo_ring[ch][rd];
      fb       = to_q15(feedback_reg);
      mix      = to_q15(wet_reg);
      fed_back = clip_sample(dry + ((delayed * fb) >>> 15));
      mixed    = clip_sample(((dry * (Q15_ONE - mix)) >>> 15) + ((delayed * mix) >>> 15));
      echo_ring[ch][write_ptr[ch]] = sample_type'(fed_back);
      write_ptr[ch] = write_ptr[ch] + 1'b1;
      want.chan   = ch;
      want.sample = sample_type'(mixed);
      echo_due.push_back(want);
   endtask

   always @(posedge clock) begin
      echo_out_t want;
      if (reset) begin
         foreach (echo_ring[c, i]) echo_ring[c][i] = '0;
         foreach (write_ptr[c]) write_ptr[c] = '0;
         delay_reg    = '0;
         feedback_reg = '0;
         wet_reg      = '0;
         echo_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (echo_due.size() == 0) begin
               $display("%0t: unexpected item, chan_out %0d sample_out %0d",
                        $time, rsp_chan_out, rsp_sample_out);
               errors++;
            end else begin
               want = echo_due.pop_front();
               if (rsp_chan_out !== want.chan) begin
                  $display("%0t: chan_out mismatch, expected %0d, actual %0d",
                           $time, want.chan, rsp_chan_out);
                  errors++;
               end
               if (rsp_sample_out !== want.sample) begin
                  $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                           $time, want.sample, rsp_sample_out);
                  errors++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_DELAY: begin
                  delay_reg = csr_wdata;
               end
               CSR_FEEDBACK: begin
                  feedback_reg = csr_wdata;
               end
               CSR_WET_MIX: begin
                  wet_reg = csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            predict_echo(req_chan, req_sample_in);
         end
      end
      fail_count   <= errors;
      echo_pending <= echo_due.size();
   end

endmodule

@@ verif/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fed_pkg::*;

   localparam logic [CSR_BITS-1:0]  CSR_SPARE  = 2'd3;
   localparam logic [GAIN_BITS-1:0] Q15_ONE    = 16'd32768;
   localparam sample_type           SAMPLE_MAX = 24'sh7FFFFF;
   localparam sample_type           SAMPLE_MIN = 24'sh800000;

   typedef enum {STALL_NONE, STALL_COIN, STALL_SPARSE, STALL_RARE} stall_kind_type;

   logic                 clock         = 1'b0;
   logic                 reset         = 1'b1;
   logic                 req_valid     = 1'b0;
   logic                 req_ready;
   logic                 req_chan      = 1'b0;
   sample_type           req_sample_in = '0;
   logic                 rsp_valid;
   logic                 rsp_ready     = 1'b0;
   logic                 rsp_chan_out;
   sample_type           rsp_sample_out;
   logic                 csr_we        = 1'b0;
   logic [CSR_BITS-1:0]  csr_index     = '0;
   logic [GAIN_BITS-1:0] csr_wdata     = '0;
   int                   fail_count;
   int                   echo_pending;

   stall_kind_type       stall_mode    = STALL_NONE;
   int                   stall_left    = 0;
   logic [1:0]           stall_tick    = '0;

   feedback_echo_delay u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_chan       (req_chan),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_chan_out   (rsp_chan_out),
      .rsp_sample_out (rsp_sample_out),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   echo_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_chan       (req_chan),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_chan_out   (rsp_chan_out),
      .rsp_sample_out (rsp_sample_out),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .echo_pending   (echo_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_kind_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      stall_tick <= stall_tick + 1'b1;
      case (stall_mode)
         STALL_NONE: begin
            rsp_ready <= 1'b1;
         end
         STALL_COIN: begin
            rsp_ready <= ($urandom_range(0, 1) == 1);
         end
         STALL_SPARSE: begin
            rsp_ready <= (stall_tick == 2'd0);
         end
         default: begin
            rsp_ready <= ($urandom_range(0, 7) != 0);
         end
      endcase
   end

   task automatic send_item(input logic ch, input sample_type s);
      req_valid     <= 1'b1;
      req_chan      <= ch;
      req_sample_in <= s;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic pause_sender(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // hold off until every predicted item has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (echo_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_BITS-1:0] idx, input logic [GAIN_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic set_echo(input logic [GAIN_BITS-1:0] echo_len,
                           input logic [GAIN_BITS-1:0] fb,
                           input logic [GAIN_BITS-1:0] mix);
      drain();
      write_reg(CSR_DELAY, echo_len);
      write_reg(CSR_FEEDBACK, fb);
      write_reg(CSR_WET_MIX, mix);
      write_reg(CSR_SPARE, 16'($urandom));
      csr_we <= 1'b0;
   endtask

   initial begin
      int                   phase;
      int                   sent;
      int                   burst;
      logic                 ch;
      sample_type           s;
      logic [GAIN_BITS-1:0] echo_len;
      logic [GAIN_BITS-1:0] fb;
      logic [GAIN_BITS-1:0] mix;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset registers: dry only, zero delay reads unwritten entries as zero
      send_item(1'b0, SAMPLE_MAX);
      send_item(1'b1, SAMPLE_MIN);
      send_item(1'b0, -24'sd1);
      send_item(1'b1, 24'sd0);

      set_echo(16'd1, Q15_ONE, Q15_ONE);
      repeat (3) send_item(1'b0, SAMPLE_MAX);
      repeat (3) send_item(1'b0, SAMPLE_MIN);
      send_item(1'b1, 24'sd12345);
      send_item(1'b1, -24'sd12345);

      // gains above unity
      set_echo(16'd2, 16'hFFFF, 16'd40000);
      send_item(1'b0, -24'sd3);
      send_item(1'b1, -24'sd1);
      send_item(1'b0, 24'sd7);
      send_item(1'b1, SAMPLE_MIN);
      send_item(1'b0, 24'sd1);

      set_echo(16'hFFFF, 16'd16384, 16'd16384);
      send_item(1'b0, 24'sd1000);
      send_item(1'b1, -24'sd1001);
      send_item(1'b0, SAMPLE_MAX);

      set_echo(16'd0, 16'd32767, 16'd1);
      send_item(1'b1, -24'sd77);
      send_item(1'b0, SAMPLE_MAX);

      for (phase = 0; phase < 12; phase++) begin
         case ($urandom_range(0, 5))
            0: echo_len = 16'd0;
            1: echo_len = 16'hFFFF;
            2: echo_len = 16'($urandom);
            default: echo_len = 16'($urandom_range(1, 48));
         endcase
         case ($urandom_range(0, 4))
            0: fb = 16'd0;
            1: fb = Q15_ONE;
            2: fb = 16'($urandom_range(32769, 65535));
            default: fb = 16'($urandom_range(0, 32768));
         endcase
         case ($urandom_range(0, 4))
            0: mix = 16'd0;
            1: mix = Q15_ONE;
            2: mix = 16'($urandom_range(32769, 65535));
            default: mix = 16'($urandom_range(0, 32768));
         endcase
         set_echo(echo_len, fb, mix);
         sent = 0;
         while (sent < 148) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
               ch = 1'($urandom_range(0, 1));
               case ($urandom_range(0, 9))
                  0: s = SAMPLE_MAX;
                  1: s = SAMPLE_MIN;
                  2, 3: s = sample_type'(int'($urandom_range(0, 4000)) - 2000);
                  default: s = sample_type'($urandom);
               endcase
               send_item(ch, s);
               sent++;
            end
            case ($urandom_range(0, 9))
               0: drain();
               1, 2, 3: begin
               end
               4: pause_sender($urandom_range(10, 20));
               default: pause_sender($urandom_range(1, 4));
            endcase
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (fail_count == 0 && echo_pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end

endmodule
